[rtl/gasp_pkg.sv]
// Shared types, codes and constants of the grid path search unit.
`default_nettype none

package gasp_pkg;

	// Command codes carried in the input word.
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	// Search status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_UNREACH  = 2'd1;
	localparam logic [1:0] STAT_SAME     = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW = 2'd3;

	// Configuration register indexes.
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam int CFG_W   = 7;
	localparam int COST_W  = 20;
	localparam int F_W     = 21;
	localparam int SEQ_W   = 32;
	// Wide enough to compare any coordinate with any side length.
	localparam int DIM_W   = 9;

	localparam logic [COST_W-1:0] COST_STRAIGHT = 20'd10;
	localparam logic [COST_W-1:0] COST_DIAG     = 20'd14;
	localparam logic [F_W-1:0]    HEUR_SCALE    = 21'd10;

	// Neighbour order: dx from -1 to 1, and within it dy from -1 to 1.
	localparam logic [7:0] DIR_XNEG = 8'b0000_0111;
	localparam logic [7:0] DIR_XPOS = 8'b1110_0000;
	localparam logic [7:0] DIR_YNEG = 8'b0010_1001;
	localparam logic [7:0] DIR_YPOS = 8'b1001_0100;

	typedef struct packed {
		logic [1:0]  command;
		logic        cell_free;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic [5:0]  goal_x;
		logic [5:0]  goal_y;
		logic [11:0] step_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] path_length;
		logic [5:0]  path_x;
		logic [5:0]  path_y;
	} out_word_t;

	typedef struct packed {
		logic clr;
		logic push;
		logic pop;
	} q_ctrl_t;

endpackage

`default_nettype wire

[rtl/gasp_queue.sv]
// Open queue: entry memory with push, and a scanning pop of the lowest f, oldest first.
`default_nettype none

module gasp_queue
	import gasp_pkg::*;
#(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire q_ctrl_t                      ctrl,
	input  wire logic [F_W-1:0]               push_f,
	input  wire logic [DATA_W-1:0]            push_data,
	output logic      [DATA_W-1:0]            pop_data,
	output logic      [$clog2(DEPTH+1)-1:0]   count,
	output logic                              busy
);

	localparam int CW    = $clog2(DEPTH+1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int ENT_W = F_W + SEQ_W + DATA_W;

	localparam logic [1:0] QS_IDLE = 2'd0;
	localparam logic [1:0] QS_SCAN = 2'd1;
	localparam logic [1:0] QS_LAST = 2'd2;
	localparam logic [1:0] QS_MOVE = 2'd3;

	logic [ENT_W-1:0]  mem [DEPTH];
	logic [1:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_ptr_q;
	logic [SEQ_W-1:0]  seq_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [ENT_W-1:0]  rdata_s1;
	logic              rvalid_s1;
	logic [IDX_W-1:0]  ridx_s1;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [ENT_W-1:0]  wdata;
	logic              have_best_q;
	logic [F_W-1:0]    best_f_q;
	logic [SEQ_W-1:0]  best_seq_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [DATA_W-1:0] best_data_q;
	logic [F_W-1:0]    r_f;
	logic [SEQ_W-1:0]  r_seq;
	logic              take;
	logic [CW-1:0]     last_idx;

	assign r_f      = rdata_s1[ENT_W-1 -: F_W];
	assign r_seq    = rdata_s1[DATA_W +: SEQ_W];
	assign last_idx = count_q - CW'(1);
	assign take     = rvalid_s1 && (!have_best_q || (r_f < best_f_q) ||
	                  ((r_f == best_f_q) && (r_seq < best_seq_q)));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_ptr_q[IDX_W-1:0];
		we      = 1'b0;
		waddr   = count_q[IDX_W-1:0];
		wdata   = {push_f, seq_q, push_data};
		unique case (state_q)
			QS_IDLE: begin
				we = ctrl.push;
			end
			QS_SCAN: begin
				rd_en = (rd_ptr_q != count_q);
			end
			QS_LAST: begin
				rd_en   = 1'b1;
				rd_addr = last_idx[IDX_W-1:0];
			end
			QS_MOVE: begin
				// The last entry fills the hole; the sequence number keeps the age order.
				we    = 1'b1;
				waddr = best_idx_q;
				wdata = rdata_s1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		ridx_s1 <= rd_addr;
		if (state_q == QS_SCAN && take) begin
			best_f_q    <= r_f;
			best_seq_q  <= r_seq;
			best_idx_q  <= ridx_s1;
			best_data_q <= rdata_s1[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= QS_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			seq_q       <= '0;
			rvalid_s1   <= 1'b0;
			have_best_q <= 1'b0;
		end else begin
			rvalid_s1 <= rd_en;
			unique case (state_q)
				QS_IDLE: begin
					if (ctrl.clr) begin
						count_q <= '0;
						seq_q   <= '0;
					end else if (ctrl.push) begin
						count_q <= count_q + CW'(1);
						seq_q   <= seq_q + SEQ_W'(1);
					end else if (ctrl.pop) begin
						rd_ptr_q    <= '0;
						have_best_q <= 1'b0;
						state_q     <= QS_SCAN;
					end
				end
				QS_SCAN: begin
					if (take) begin
						have_best_q <= 1'b1;
					end
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end else begin
						state_q <= QS_LAST;
					end
				end
				QS_LAST: begin
					state_q <= QS_MOVE;
				end
				QS_MOVE: begin
					count_q <= last_idx;
					state_q <= QS_IDLE;
				end
				default: begin
					state_q <= QS_IDLE;
				end
			endcase
		end
	end

	assign pop_data = best_data_q;
	assign count    = count_q;
	assign busy     = (state_q != QS_IDLE);

endmodule

`default_nettype wire

[rtl/grid_astar_path_search_unit.sv]
// Top level of the grid path search unit: command sequencer, map, node and path memories.
`default_nettype none

// The unit takes command words on the item channel (item_valid, item_stall, item) and
// returns exactly one result word per command on the result channel (result_valid,
// result_stall, result). Both channels move a word at a clock edge with valid high and
// stall low. A load command writes one map cell and is taken one per cycle while the
// result side keeps up; its result is in the output register in the next cycle.
// A read command reads the path memory as the word is taken, latches the step in S_RDP
// and issues the result from S_RESP; a read past the end of the path skips the memory
// read and S_RDP and goes straight to S_RESP. A search command inside the grid first
// clears the node memory, one entry per cycle over all MAX_SIDE * MAX_SIDE entries,
// then expands cells. Each expansion pops the open queue, which scans every queued
// entry once, then checks eight neighbours through the node memory read port. The
// path is then traced back from the goal one cell at a time through S_WALKW and
// S_WALKR, with each cell written into the path memory in S_WALKW. The item channel is
// stalled until the current command has finished its work; a result held back by
// result_stall waits in the output register, and the unit waits with it. The grid size
// registers are written through cfg_we, cfg_index and cfg_data and reset to 64 by 64.
// Reset clears the status, path length, queue fill and output valid; map contents are
// undefined until loaded.
module grid_astar_path_search_unit
	import gasp_pkg::*;
#(
	parameter int MAX_SIDE    = 64,
	parameter int QUEUE_DEPTH = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire in_word_t         item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output out_word_t             result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int SIDE_W = $clog2(MAX_SIDE);
	localparam int XY_W   = 2 * SIDE_W;
	localparam int CELLS  = MAX_SIDE * MAX_SIDE;
	localparam int CELL_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int CQ_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int NODE_W = 1 + XY_W + COST_W;
	localparam int SC_W   = (CNT_W > 13) ? CNT_W : 13;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RESP  = 4'd1;
	localparam logic [3:0] S_RDP   = 4'd2;
	localparam logic [3:0] S_CLR   = 4'd3;
	localparam logic [3:0] S_INIT  = 4'd4;
	localparam logic [3:0] S_POP   = 4'd5;
	localparam logic [3:0] S_POPW  = 4'd6;
	localparam logic [3:0] S_CUR   = 4'd7;
	localparam logic [3:0] S_NBC   = 4'd8;
	localparam logic [3:0] S_NBE   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;
	localparam logic [3:0] S_GOALE = 4'd11;
	localparam logic [3:0] S_WALKW = 4'd12;
	localparam logic [3:0] S_WALKR = 4'd13;

	function automatic logic [CELL_W-1:0] cell_addr(input logic [SIDE_W-1:0] x,
	                                                input logic [SIDE_W-1:0] y);
		cell_addr = CELL_W'(y) * CELL_W'(MAX_SIDE) + CELL_W'(x);
	endfunction

	function automatic logic [F_W-1:0] heur(input logic [SIDE_W-1:0] ax,
	                                        input logic [SIDE_W-1:0] ay,
	                                        input logic [SIDE_W-1:0] bx,
	                                        input logic [SIDE_W-1:0] by);
		logic [SIDE_W-1:0] ddx;
		logic [SIDE_W-1:0] ddy;
		ddx  = (ax > bx) ? ax - bx : bx - ax;
		ddy  = (ay > by) ? ay - by : by - ay;
		heur = F_W'({1'b0, ddx} + {1'b0, ddy}) * HEUR_SCALE;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			clamp_side = DIM_W'(1);
		end else if (DIM_W'(v) > DIM_W'(MAX_SIDE)) begin
			clamp_side = DIM_W'(MAX_SIDE);
		end else begin
			clamp_side = DIM_W'(v);
		end
	endfunction

	// Memories
	logic              map_mem  [CELLS];
	logic [NODE_W-1:0] node_mem [CELLS];
	logic [XY_W-1:0]   path_mem [CELLS];

	// Control registers
	logic [3:0]        state_q;
	logic              out_valid_q;
	out_word_t         out_data_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  pcount_q;
	logic [CFG_W-1:0]  gw_q;
	logic [CFG_W-1:0]  gh_q;

	// Search datapath registers
	logic [SIDE_W-1:0] sx_q, sy_q, gx_q, gy_q;
	logic [DIM_W-1:0]  w_q, h_q;
	logic [CELL_W-1:0] start_addr_q, goal_addr_q;
	logic [CELL_W-1:0] clr_ptr_q;
	logic [SIDE_W-1:0] cx_q, cy_q;
	logic [COST_W-1:0] gcur_q;
	logic [2:0]        dir_q;
	logic              diag_q;
	logic [SIDE_W-1:0] nbx_q, nby_q;
	logic [CELL_W-1:0] nb_addr_q;
	logic [CELL_W-1:0] k_q;
	logic [XY_W-1:0]   c_q;
	logic [5:0]        rpx_q, rpy_q;
	logic              rd_hit_q;

	// Memory read data
	logic              map_rdata;
	logic [NODE_W-1:0] node_rdata;
	logic [XY_W-1:0]   path_rdata;

	// Queue
	q_ctrl_t           qctrl;
	logic [F_W-1:0]    q_push_f;
	logic [XY_W-1:0]   q_push_data;
	logic [XY_W-1:0]   q_pop_data;
	logic [CQ_W-1:0]   q_count;
	logic              q_busy;

	// Combinational control
	logic              acc;
	logic              slot_free;
	logic              deliver;
	out_word_t         deliver_data;
	logic [DIM_W-1:0]  in_w, in_h;
	logic              in_oob;
	logic              in_on_map;
	logic              rd_hit;
	logic [CNT_W-1:0]  rd_pos;
	logic              xneg, xpos, yneg, ypos;
	logic [DIM_W-1:0]  nxd, nyd;
	logic              nb_oob;
	logic [CELL_W-1:0] nb_addr;
	logic              node_valid;
	logic [XY_W-1:0]   node_parent;
	logic [COST_W-1:0] node_cost;
	logic [COST_W-1:0] ng;
	logic              upd;
	logic              q_full;
	logic              pop_goal;
	logic              c_is_start;
	logic              node_we, node_re;
	logic [CELL_W-1:0] node_waddr, node_raddr;
	logic [NODE_W-1:0] node_wdata;
	logic              map_we;
	logic [CELL_W-1:0] map_waddr;
	logic              path_re;
	logic [CELL_W-1:0] path_raddr;

	assign acc        = item_valid && (state_q == S_IDLE);
	assign item_stall = (state_q != S_IDLE);
	assign slot_free  = !out_valid_q || !result_stall;

	assign in_w      = clamp_side(gw_q);
	assign in_h      = clamp_side(gh_q);
	assign in_oob    = (DIM_W'(item.cell_x) >= in_w) || (DIM_W'(item.cell_y) >= in_h) ||
	                   (DIM_W'(item.goal_x) >= in_w) || (DIM_W'(item.goal_y) >= in_h);
	assign in_on_map = (DIM_W'(item.cell_x) < DIM_W'(MAX_SIDE)) &&
	                   (DIM_W'(item.cell_y) < DIM_W'(MAX_SIDE));
	assign rd_hit    = SC_W'(item.step_index) < SC_W'(pcount_q);
	// The path is stored goal first, so step s sits at pcount - 1 - s.
	assign rd_pos    = pcount_q - CNT_W'(1) - CNT_W'(item.step_index);

	// Neighbour geometry for the current direction.
	assign xneg    = DIR_XNEG[dir_q];
	assign xpos    = DIR_XPOS[dir_q];
	assign yneg    = DIR_YNEG[dir_q];
	assign ypos    = DIR_YPOS[dir_q];
	assign nxd     = xpos ? DIM_W'(cx_q) + DIM_W'(1) :
	                 xneg ? DIM_W'(cx_q) - DIM_W'(1) : DIM_W'(cx_q);
	assign nyd     = ypos ? DIM_W'(cy_q) + DIM_W'(1) :
	                 yneg ? DIM_W'(cy_q) - DIM_W'(1) : DIM_W'(cy_q);
	assign nb_oob  = (xneg && cx_q == '0) || (yneg && cy_q == '0) ||
	                 (nxd >= w_q) || (nyd >= h_q);
	assign nb_addr = cell_addr(nxd[SIDE_W-1:0], nyd[SIDE_W-1:0]);

	assign node_valid  = node_rdata[NODE_W-1];
	assign node_parent = node_rdata[NODE_W-2 -: XY_W];
	assign node_cost   = node_rdata[COST_W-1:0];
	assign ng          = gcur_q + (diag_q ? COST_DIAG : COST_STRAIGHT);
	assign upd         = (state_q == S_NBE) && map_rdata &&
	                     (!node_valid || (ng < node_cost));
	assign q_full      = (q_count == CQ_W'(QUEUE_DEPTH));
	assign pop_goal    = (q_pop_data == {gx_q, gy_q});
	assign c_is_start  = (c_q == {sx_q, sy_q});

	always_comb begin
		qctrl.clr   = acc && (item.command == CMD_SEARCH);
		qctrl.push  = (state_q == S_INIT) || (upd && !q_full);
		qctrl.pop   = (state_q == S_POP) && (q_count != '0);
		q_push_f    = heur(sx_q, sy_q, gx_q, gy_q);
		q_push_data = {sx_q, sy_q};
		if (state_q == S_NBE) begin
			q_push_f    = F_W'(ng) + heur(nbx_q, nby_q, gx_q, gy_q);
			q_push_data = {nbx_q, nby_q};
		end
	end

	always_comb begin
		node_we    = 1'b0;
		node_waddr = clr_ptr_q;
		node_wdata = '0;
		node_re    = 1'b0;
		node_raddr = nb_addr;
		unique case (state_q)
			S_CLR: begin
				node_we = 1'b1;
			end
			S_INIT: begin
				node_we    = 1'b1;
				node_waddr = start_addr_q;
				node_wdata = {1'b1, sx_q, sy_q, COST_W'(0)};
			end
			S_POPW: begin
				node_re    = !q_busy;
				node_raddr = cell_addr(q_pop_data[XY_W-1 -: SIDE_W], q_pop_data[SIDE_W-1:0]);
			end
			S_NBC: begin
				node_re = !nb_oob;
			end
			S_NBE: begin
				node_we    = upd;
				node_waddr = nb_addr_q;
				node_wdata = {1'b1, cx_q, cy_q, ng};
			end
			S_FIN: begin
				node_re    = 1'b1;
				node_raddr = goal_addr_q;
			end
			S_WALKW: begin
				node_re    = !c_is_start;
				node_raddr = cell_addr(c_q[XY_W-1 -: SIDE_W], c_q[SIDE_W-1:0]);
			end
			default: begin
				node_re = 1'b0;
			end
		endcase
	end

	assign map_we     = acc && (item.command == CMD_LOAD) && in_on_map;
	assign map_waddr  = cell_addr(SIDE_W'(item.cell_x), SIDE_W'(item.cell_y));
	assign path_re    = acc && (item.command == CMD_READ) && rd_hit;
	assign path_raddr = rd_pos[CELL_W-1:0];

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= item.cell_free;
		end
		if (state_q == S_NBC) begin
			map_rdata <= map_mem[nb_addr];
		end
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		if (node_re) begin
			node_rdata <= node_mem[node_raddr];
		end
		if (state_q == S_WALKW) begin
			path_mem[k_q] <= c_q;
		end
		if (path_re) begin
			path_rdata <= path_mem[path_raddr];
		end
	end

	gasp_queue #(
		.DEPTH  (QUEUE_DEPTH),
		.DATA_W (XY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (qctrl),
		.push_f    (q_push_f),
		.push_data (q_push_data),
		.pop_data  (q_pop_data),
		.count     (q_count),
		.busy      (q_busy)
	);

	// Loads and idle commands answer at once if the slot is free; the rest from S_RESP.
	always_comb begin
		deliver = 1'b0;
		if (state_q == S_RESP) begin
			deliver = slot_free;
		end else if (acc && (item.command == CMD_LOAD || item.command == CMD_NONE)) begin
			deliver = slot_free;
		end
		deliver_data.status      = status_q;
		deliver_data.path_length = 13'(pcount_q);
		deliver_data.path_x      = (state_q == S_RESP) ? rpx_q : 6'd0;
		deliver_data.path_y      = (state_q == S_RESP) ? rpy_q : 6'd0;
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			out_data_q <= deliver_data;
		end
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					rpx_q    <= 6'd0;
					rpy_q    <= 6'd0;
					rd_hit_q <= rd_hit;
					if (item.command == CMD_SEARCH) begin
						sx_q         <= SIDE_W'(item.cell_x);
						sy_q         <= SIDE_W'(item.cell_y);
						gx_q         <= SIDE_W'(item.goal_x);
						gy_q         <= SIDE_W'(item.goal_y);
						w_q          <= in_w;
						h_q          <= in_h;
						start_addr_q <= cell_addr(SIDE_W'(item.cell_x), SIDE_W'(item.cell_y));
						goal_addr_q  <= cell_addr(SIDE_W'(item.goal_x), SIDE_W'(item.goal_y));
						clr_ptr_q    <= '0;
					end
				end
			end
			S_RDP: begin
				if (rd_hit_q) begin
					rpx_q <= 6'(path_rdata[XY_W-1 -: SIDE_W]);
					rpy_q <= 6'(path_rdata[SIDE_W-1:0]);
				end
			end
			S_CLR: begin
				clr_ptr_q <= clr_ptr_q + CELL_W'(1);
			end
			S_POPW: begin
				if (!q_busy) begin
					cx_q <= q_pop_data[XY_W-1 -: SIDE_W];
					cy_q <= q_pop_data[SIDE_W-1:0];
				end
			end
			S_CUR: begin
				gcur_q <= node_cost;
				dir_q  <= 3'd0;
			end
			S_NBC: begin
				nbx_q     <= nxd[SIDE_W-1:0];
				nby_q     <= nyd[SIDE_W-1:0];
				nb_addr_q <= nb_addr;
				diag_q    <= (xneg || xpos) && (yneg || ypos);
				if (nb_oob) begin
					dir_q <= dir_q + 3'd1;
				end
			end
			S_NBE: begin
				dir_q <= dir_q + 3'd1;
			end
			S_GOALE: begin
				k_q <= '0;
				c_q <= {gx_q, gy_q};
			end
			S_WALKR: begin
				c_q <= node_parent;
				k_q <= k_q + CELL_W'(1);
			end
			default: begin
				rd_hit_q <= rd_hit_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			pcount_q    <= '0;
			gw_q        <= CFG_W'(64);
			gh_q        <= CFG_W'(64);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  gw_q <= cfg_data;
					REG_GRID_HEIGHT: gh_q <= cfg_data;
					default:         gw_q <= gw_q;
				endcase
			end

			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (item.command)
							CMD_SEARCH: begin
								pcount_q <= '0;
								if (in_oob) begin
									status_q <= STAT_UNREACH;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_CLR;
								end
							end
							CMD_READ: begin
								state_q <= rd_hit ? S_RDP : S_RESP;
							end
							default: begin
								state_q <= slot_free ? S_IDLE : S_RESP;
							end
						endcase
					end
				end
				S_RESP: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RDP: begin
					state_q <= S_RESP;
				end
				S_CLR: begin
					if (clr_ptr_q == CELL_W'(CELLS - 1)) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					state_q <= S_POP;
				end
				S_POP: begin
					state_q <= (q_count == '0) ? S_FIN : S_POPW;
				end
				S_POPW: begin
					if (!q_busy) begin
						state_q <= pop_goal ? S_FIN : S_CUR;
					end
				end
				S_CUR: begin
					state_q <= S_NBC;
				end
				S_NBC: begin
					if (!nb_oob) begin
						state_q <= S_NBE;
					end else if (dir_q == 3'd7) begin
						state_q <= S_POP;
					end
				end
				S_NBE: begin
					if (upd && q_full) begin
						status_q <= STAT_OVERFLOW;
						state_q  <= S_RESP;
					end else begin
						state_q <= (dir_q == 3'd7) ? S_POP : S_NBC;
					end
				end
				S_FIN: begin
					state_q <= S_GOALE;
				end
				S_GOALE: begin
					if (!node_valid) begin
						status_q <= STAT_UNREACH;
						state_q  <= S_RESP;
					end else if (start_addr_q == goal_addr_q) begin
						status_q <= STAT_SAME;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_WALKW;
					end
				end
				S_WALKW: begin
					if (c_is_start) begin
						pcount_q <= CNT_W'(k_q) + CNT_W'(1);
						status_q <= STAT_OK;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_WALKR;
					end
				end
				S_WALKR: begin
					state_q <= S_WALKW;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_data_q;

endmodule

`default_nettype wire

[test/gasp_result_checker.sv]
// Checker for the grid path search unit: predicts each result word and compares it.
`timescale 1ns / 1ps

module gasp_result_checker
	import gasp_pkg::*;
#(
	parameter int MAX_SIDE    = 64,
	parameter int QUEUE_DEPTH = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic             item_stall,
	input  wire in_word_t         item,
	input  wire logic             result_valid,
	input  wire logic             result_stall,
	input  wire out_word_t        result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    words_owed
);

	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int unsigned NO_LINK = CELLS;

	bit          cell_open [CELLS];
	int unsigned cost_to   [CELLS];
	int unsigned came_from [CELLS];
	int unsigned route     [$];
	int unsigned frontier_f[$];
	int unsigned frontier_c[$];
	logic [1:0]  search_status;
	logic [CFG_W-1:0] width_reg, height_reg;
	out_word_t   owed_words[$];

	function automatic int unsigned clamp_side(input logic [CFG_W-1:0] v);
		if (v < 1) return 1;
		if (v > MAX_SIDE) return MAX_SIDE;
		return v;
	endfunction

	function automatic int unsigned manhattan(input int unsigned a, input int unsigned b);
		int ax, ay, bx, by, ddx, ddy;
		ax = a % MAX_SIDE; ay = a / MAX_SIDE;
		bx = b % MAX_SIDE; by = b / MAX_SIDE;
		ddx = ax > bx ? ax - bx : bx - ax;
		ddy = ay > by ? ay - by : by - ay;
		return (ddx + ddy) * 10;
	endfunction

	function automatic void find_route(input int unsigned sx, input int unsigned sy,
			input int unsigned gx, input int unsigned gy);
		int unsigned w, h, start, goal, cur, nb, ng, best, c, guard;
		int nx, ny;
		bit overflow;
		w = clamp_side(width_reg);
		h = clamp_side(height_reg);
		route.delete();
		frontier_f.delete();
		frontier_c.delete();
		overflow = 0;
		if (sx >= w || sy >= h || gx >= w || gy >= h) begin
			search_status = STAT_UNREACH;
			return;
		end
		foreach (came_from[i]) came_from[i] = NO_LINK;
		start = sy * MAX_SIDE + sx;
		goal = gy * MAX_SIDE + gx;
		came_from[start] = start;
		cost_to[start] = 0;
		frontier_f.insert(frontier_f.size(), manhattan(start, goal));
		frontier_c.insert(frontier_c.size(), start);
		while (frontier_c.size() > 0 && !overflow) begin
			// Lowest f wins; the strict compare keeps the earliest entry among ties.
			best = 0;
			for (int k = 1; k < frontier_c.size(); k++)
				if (frontier_f[k] < frontier_f[best]) best = k;
			cur = frontier_c[best];
			frontier_f.delete(best);
			frontier_c.delete(best);
			if (cur == goal) break;
			for (int dx = -1; dx <= 1; dx++) begin
				for (int dy = -1; dy <= 1; dy++) begin
					if (overflow || (dx == 0 && dy == 0)) continue;
					nx = int'(cur % MAX_SIDE) + dx;
					ny = int'(cur / MAX_SIDE) + dy;
					if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) continue;
					nb = ny * MAX_SIDE + nx;
					if (!cell_open[nb]) continue;
					ng = cost_to[cur] + ((dx != 0 && dy != 0) ? 14 : 10);
					if (came_from[nb] == NO_LINK || ng < cost_to[nb]) begin
						cost_to[nb] = ng;
						came_from[nb] = cur;
						if (frontier_c.size() >= QUEUE_DEPTH) begin
							overflow = 1;
						end else begin
							frontier_f.insert(frontier_f.size(), ng + manhattan(nb, goal));
							frontier_c.insert(frontier_c.size(), nb);
						end
					end
				end
			end
		end
		if (overflow) begin
			search_status = STAT_OVERFLOW;
		end else if (came_from[goal] == NO_LINK) begin
			search_status = STAT_UNREACH;
		end else if (start == goal) begin
			search_status = STAT_SAME;
		end else begin
			c = goal;
			guard = 0;
			route.push_front(c);
			while (c != start && guard < CELLS) begin
				c = came_from[c];
				route.push_front(c);
				guard++;
			end
			search_status = STAT_OK;
		end
	endfunction

	function automatic out_word_t predict_word(input in_word_t w);
		out_word_t r;
		r = '0;
		case (w.command)
			CMD_LOAD: cell_open[w.cell_y * MAX_SIDE + w.cell_x] = w.cell_free;
			CMD_SEARCH: find_route(w.cell_x, w.cell_y, w.goal_x, w.goal_y);
			CMD_READ: begin
				if (w.step_index < route.size()) begin
					r.path_x = route[w.step_index] % MAX_SIDE;
					r.path_y = route[w.step_index] / MAX_SIDE;
				end
			end
			default: ;
		endcase
		r.status = search_status;
		r.path_length = route.size();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			width_reg <= 7'd64;
			height_reg <= 7'd64;
			search_status = STAT_OK;
			route.delete();
			owed_words.delete();
			fail_count <= 0;
			words_owed <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_GRID_WIDTH) width_reg <= cfg_data;
				else height_reg <= cfg_data;
			end
			if (item_valid && !item_stall)
				owed_words.insert(owed_words.size(), predict_word(item));
			if (result_valid && !result_stall) begin
				if (owed_words.size() == 0) begin
					$error("result word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = owed_words.pop_front();
					if (want !== result) begin
						if (want.status !== result.status)
							$error("status expected %0d got %0d", want.status, result.status);
						if (want.path_length !== result.path_length)
							$error("path_length expected %0d got %0d",
								want.path_length, result.path_length);
						if (want.path_x !== result.path_x)
							$error("path_x expected %0d got %0d", want.path_x, result.path_x);
						if (want.path_y !== result.path_y)
							$error("path_y expected %0d got %0d", want.path_y, result.path_y);
						fail_count <= fail_count + 1;
					end
				end
			end
			words_owed <= owed_words.size();
		end
	end

endmodule

[test/tb_top.sv]
// Top of the grid path search testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import gasp_pkg::*;

	localparam int MAX_SIDE = 64;
	// A small queue lets large open grids run into the overflow case quickly.
	localparam int QUEUE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 30_000_000;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	in_word_t         item;
	logic             result_valid;
	logic             result_stall;
	out_word_t        result;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int               fail_count;
	int               words_owed;
	int               cycle_count;

	// Idling mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
	int idle_mode;
	int grid_w, grid_h;
	bit loaded [MAX_SIDE * MAX_SIDE];

	grid_astar_path_search_unit #(
		.MAX_SIDE   (MAX_SIDE),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	gasp_result_checker #(
		.MAX_SIDE   (MAX_SIDE),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.words_owed  (words_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver decides afresh at every falling edge whether to stall the next word.
	always @(negedge clk) begin
		if (idle_mode == 2)
			result_stall <= ($urandom_range(0, 99) < 47);
		else if (idle_mode == 3)
			result_stall <= ($urandom_range(0, 99) < 25);
		else
			result_stall <= 1'b0;
	end

	// A hung handshake must not hang the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("grid_astar_path_search_unit verification failed");
			$finish;
		end
	end

	// Offers one word and returns at the falling edge after it was taken. Valid is
	// left high, so back-to-back words need no second assignment in one step; a
	// random gap lowers it first.
	task automatic send_word(input in_word_t w);
		int pct;
		pct = (idle_mode == 1) ? 47 : (idle_mode == 3) ? 25 : 0;
		if ($urandom_range(0, 99) < pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Drops valid and waits until every predicted word has come back.
	task automatic drain();
		item_valid <= 1'b0;
		@(negedge clk);
		while (words_owed != 0) @(negedge clk);
	endtask

	task automatic load_cell(input int x, input int y, input bit open_cell);
		in_word_t w;
		w = in_word_t'({$urandom, $urandom});
		w.command = CMD_LOAD;
		w.cell_x = x;
		w.cell_y = y;
		w.cell_free = open_cell;
		loaded[y * MAX_SIDE + x] = 1'b1;
		send_word(w);
	endtask

	task automatic search(input int sx, input int sy, input int gx, input int gy);
		in_word_t w;
		w = in_word_t'({$urandom, $urandom});
		w.command = CMD_SEARCH;
		w.cell_x = sx;
		w.cell_y = sy;
		w.goal_x = gx;
		w.goal_y = gy;
		send_word(w);
	endtask

	task automatic read_step(input int idx);
		in_word_t w;
		w = in_word_t'({$urandom, $urandom});
		w.command = CMD_READ;
		w.step_index = idx;
		send_word(w);
	endtask

	// Registers change only with the unit idle; the extra cycles cover the
	// output register and any trailing internal work.
	task automatic set_grid(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
		drain();
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= wv;
		@(negedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data <= hv;
		@(negedge clk);
		cfg_we <= 1'b0;
		grid_w = (wv < 1) ? 1 : (wv > MAX_SIDE) ? MAX_SIDE : wv;
		grid_h = (hv < 1) ? 1 : (hv > MAX_SIDE) ? MAX_SIDE : hv;
		// Every cell a search can look at must hold a known value first.
		for (int y = 0; y < grid_h; y++)
			for (int x = 0; x < grid_w; x++)
				if (!loaded[y * MAX_SIDE + x])
					load_cell(x, y, $urandom_range(0, 99) < 80);
	endtask

	// Mostly searches inside the grid and path reads, with loads that reshape
	// the map and a few out-of-bounds searches, over-long reads and idle commands.
	task automatic random_phase(input int count, input bit hold_off);
		in_word_t w;
		int pick;
		for (int n = 0; n < count; n++) begin
			if (hold_off && n == count / 2) drain();
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				if ($urandom_range(0, 9) == 0)
					search($urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 63), $urandom_range(0, 63));
				else
					search($urandom_range(0, grid_w - 1), $urandom_range(0, grid_h - 1),
						$urandom_range(0, grid_w - 1), $urandom_range(0, grid_h - 1));
			end else if (pick < 65) begin
				if ($urandom_range(0, 9) == 0) read_step($urandom_range(0, 4095));
				else read_step($urandom_range(0, 24));
			end else if (pick < 95) begin
				if ($urandom_range(0, 4) == 0)
					load_cell($urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 1));
				else
					load_cell($urandom_range(0, grid_w - 1), $urandom_range(0, grid_h - 1),
						$urandom_range(0, 99) < 80);
			end else begin
				w = in_word_t'({$urandom, $urandom});
				w.command = CMD_NONE;
				send_word(w);
			end
		end
	endtask

	initial begin
		int settle;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data = '0;
		idle_mode = 0;
		cycle_count = 0;
		grid_w = MAX_SIDE;
		grid_h = MAX_SIDE;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a single-cell grid, where start and goal coincide and any
		// other goal lies out of bounds.
		set_grid(7'd1, 7'd1);
		search(0, 0, 0, 0);
		search(0, 0, 1, 0);
		read_step(0);
		// A two by two open grid: one diagonal step, then reads on and past the path.
		set_grid(7'd2, 7'd2);
		for (int y = 0; y < 2; y++)
			for (int x = 0; x < 2; x++)
				load_cell(x, y, 1'b1);
		search(0, 0, 1, 1);
		read_step(0);
		read_step(1);
		read_step(2);
		read_step(4095);
		// Blocked goal cannot be reached; a blocked start still expands.
		load_cell(1, 1, 1'b0);
		search(0, 0, 1, 1);
		load_cell(0, 0, 1'b0);
		search(0, 0, 1, 0);
		read_step(1);
		load_cell(0, 0, 1'b1);
		search(1, 0, 0, 1);
		read_step(0);
		begin
			in_word_t w;
			w = in_word_t'({$urandom, $urandom});
			w.command = CMD_NONE;
			send_word(w);
		end

		// Random phases over a spread of grid settings, the clamped extremes among them.
		set_grid(7'd8, 7'd8);
		random_phase(100, 1'b0);
		idle_mode = 1;
		set_grid(7'd0, 7'd127);
		random_phase(100, 1'b1);
		idle_mode = 2;
		set_grid(7'd12, 7'd10);
		random_phase(110, 1'b0);
		idle_mode = 3;
		set_grid(7'd127, 7'd0);
		random_phase(100, 1'b0);
		idle_mode = 0;
		set_grid(7'd9, 7'd12);
		random_phase(90, 1'b0);
		idle_mode = 1;
		set_grid(7'd5, 7'd16);
		random_phase(110, 1'b0);
		idle_mode = 2;
		set_grid(7'd3, 7'd2);
		random_phase(90, 1'b0);
		idle_mode = 3;
		set_grid(7'd16, 7'd6);
		random_phase(100, 1'b0);

		drain();
		settle = 0;
		while (settle < 50) begin
			@(negedge clk);
			settle++;
		end
		if (fail_count == 0 && words_owed == 0) begin
			$display("grid_astar_path_search_unit verification clean");
		end else begin
			$display("grid_astar_path_search_unit verification failed");
		end
		$finish;
	end

endmodule
